// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the gradient bucket core.
// Holds no logic of its own; included by the top-level core to check its behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden state");
`else
`define ASSERT_CLK_RST(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/gasb_pkg.sv =====
// Package of the gradient angle and strength bucket core: widths, fixed-point
// constants, codes and payload structs. Depends on nothing.
`default_nettype none
package gasb_pkg;

    // Fixed point format
    localparam int FB = 24;
    localparam int QW = FB + 1;      // ratio, quotient and denominator width
    localparam int OW = FB + 3;      // angle offset and theta width (up to two pi)
    localparam int GW = 18;          // signed gradient width
    localparam int MW = 17;          // gradient magnitude width
    localparam int SQW = 34;         // gx^2 + gy^2 width
    localparam int AW = 7;           // angle_count register width
    localparam int BQ = 7;           // bucket quotient bits
    localparam int PW = OW + AW;     // theta * angle_count width

    // Constants rounded from 48-bit fractions
    localparam logic [63:0] PI_Q48 = 64'h3243F6A8885A3;
    localparam logic [63:0] C028_Q48 = 64'd78812993478984;
    localparam logic [63:0] HALF_Q48 = 64'd1 << (47 - FB);
    localparam logic [63:0] PI_FX = (PI_Q48 + HALF_Q48) >> (48 - FB);
    localparam logic [63:0] PI_HALF_FX = ((PI_Q48 >> 1) + HALF_Q48) >> (48 - FB);
    localparam logic [63:0] C028_FX = (C028_Q48 + HALF_Q48) >> (48 - FB);
    localparam logic [63:0] TWO_PI_FX = 64'd2 * PI_FX;
    localparam logic [QW-1:0] ONE_Q = QW'(64'd1 << FB);
    localparam logic [QW-1:0] C028_Q = QW'(C028_FX);

    // Strength thresholds: squares of 8160 and 16320
    localparam logic [SQW-1:0] WEAK_LIM = SQW'(64'd66585600);
    localparam logic [SQW-1:0] STRONG_LIM = SQW'(64'd266342400);
    localparam logic [1:0] STR_WEAK = 2'd0;
    localparam logic [1:0] STR_MEDIUM = 2'd1;
    localparam logic [1:0] STR_STRONG = 2'd2;

    // Register map
    localparam logic REG_ANGLE_COUNT = 1'b0;
    localparam logic [AW-1:0] ANGLE_COUNT_RST = 7'd24;

    // Cycles from accepted start to result strobe
    localparam int LATENCY = 3 + QW + 2 + QW + 3 + BQ;

    typedef struct packed {
        logic [7:0] pixel_r0_c0;
        logic [7:0] pixel_r0_c1;
        logic [7:0] pixel_r0_c2;
        logic [7:0] pixel_r1_c0;
        logic [7:0] pixel_r1_c1;
        logic [7:0] pixel_r1_c2;
        logic [7:0] pixel_r2_c0;
        logic [7:0] pixel_r2_c1;
        logic [7:0] pixel_r2_c2;
    } t_patch;

    typedef struct packed {
        logic [5:0] angle_bucket;
        logic [1:0] strength_class;
    } t_result;

    // Sideband that rides along the divider pipelines
    typedef struct packed {
        logic [1:0]    strength;
        logic          neg;      // ratio term is subtracted
        logic [OW-1:0] offp;     // quadrant offset plus pi
    } t_side;

endpackage
`default_nettype wire

// ===== src/gasb_front.sv =====
// Front end: gradients, squared magnitude, strength class and divider setup.
// Three register stages; uses gasb_pkg.
`default_nettype none
module gasb_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire gasb_pkg::t_patch  i_patch,
    output logic                   o_valid,
    output logic [gasb_pkg::QW-1:0] o_num,
    output logic [gasb_pkg::QW-1:0] o_den,
    output gasb_pkg::t_side        o_side
);

    localparam int GW = gasb_pkg::GW;
    localparam int MW = gasb_pkg::MW;
    localparam int SQW = gasb_pkg::SQW;
    localparam int QW = gasb_pkg::QW;
    localparam int OW = gasb_pkg::OW;
    localparam logic signed [GW-1:0] K_EDGE = 18'sd47;
    localparam logic signed [GW-1:0] K_MID = 18'sd162;
    localparam logic [OW-1:0] PI_O = OW'(gasb_pkg::PI_FX);
    localparam logic [OW-1:0] PI_HALF_O = OW'(gasb_pkg::PI_HALF_FX);
    localparam logic [OW-1:0] TWO_PI_O = OW'(gasb_pkg::TWO_PI_FX);

    function automatic logic signed [GW-1:0] px(input logic [7:0] v);
        return $signed({{(GW-8){1'b0}}, v});
    endfunction

    logic [2:0] r_v;
    logic signed [GW-1:0] r_gx, r_gy;
    logic signed [GW-1:0] n_gx, n_gy;
    logic [MW-1:0] r_magx, r_magy, n_magx, n_magy;
    logic [SQW-1:0] r_gx2, r_gy2, n_mag2;
    logic r_sx, r_sy, r_zx, r_zy;
    logic [QW-1:0] r_num, r_den, n_num, n_den;
    gasb_pkg::t_side r_side, n_side;

    // stage 1: weighted column and row differences
    always_comb begin
        n_gx = K_EDGE * (px(i_patch.pixel_r0_c0) - px(i_patch.pixel_r0_c2))
             + K_MID  * (px(i_patch.pixel_r1_c0) - px(i_patch.pixel_r1_c2))
             + K_EDGE * (px(i_patch.pixel_r2_c0) - px(i_patch.pixel_r2_c2));
        n_gy = K_EDGE * (px(i_patch.pixel_r0_c0) - px(i_patch.pixel_r2_c0))
             + K_MID  * (px(i_patch.pixel_r0_c1) - px(i_patch.pixel_r2_c1))
             + K_EDGE * (px(i_patch.pixel_r0_c2) - px(i_patch.pixel_r2_c2));
    end

    // stage 2: magnitudes, signs, squares
    always_comb begin
        n_magx = r_gx[GW-1] ? MW'(-r_gx) : MW'(r_gx);
        n_magy = r_gy[GW-1] ? MW'(-r_gy) : MW'(r_gy);
    end

    // stage 3: strength and octant selection
    always_comb begin
        n_mag2 = r_gx2 + r_gy2;
        if (n_mag2 < gasb_pkg::WEAK_LIM) begin
            n_side.strength = gasb_pkg::STR_WEAK;
        end else if (n_mag2 > gasb_pkg::STRONG_LIM) begin
            n_side.strength = gasb_pkg::STR_STRONG;
        end else begin
            n_side.strength = gasb_pkg::STR_MEDIUM;
        end
        priority if (r_zx) begin
            // vertical or flat: fixed angle, ratio term forced to zero
            n_num = '0;
            n_den = QW'(1);
            n_side.neg = 1'b0;
            if (r_zy) n_side.offp = PI_O;
            else if (r_sy) n_side.offp = PI_O - PI_HALF_O;
            else n_side.offp = PI_O + PI_HALF_O;
        end else if (r_magy < r_magx) begin
            n_num = QW'(r_magy);
            n_den = QW'(r_magx);
            n_side.neg = r_sx ^ r_sy;
            if (!r_sx) n_side.offp = PI_O;
            else if (r_sy) n_side.offp = '0;
            else n_side.offp = TWO_PI_O;
        end else begin
            n_num = QW'(r_magx);
            n_den = QW'(r_magy);
            n_side.neg = ~(r_sx ^ r_sy);
            n_side.offp = r_sy ? PI_HALF_O : PI_O + PI_HALF_O;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
        r_gx <= n_gx;
        r_gy <= n_gy;
        r_magx <= n_magx;
        r_magy <= n_magy;
        r_sx <= r_gx[GW-1];
        r_sy <= r_gy[GW-1];
        r_zx <= (r_gx == '0);
        r_zy <= (r_gy == '0);
        r_gx2 <= SQW'(n_magx) * SQW'(n_magx);
        r_gy2 <= SQW'(n_magy) * SQW'(n_magy);
        r_num <= n_num;
        r_den <= n_den;
        r_side <= n_side;
    end

    assign o_valid = r_v[2];
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_side = r_side;

endmodule
`default_nettype wire

// ===== src/gasb_div.sv =====
// Pipelined restoring divider: quotient of (num << FB) / den with num <= den,
// one quotient bit per stage. Uses gasb_pkg.
`default_nettype none
module gasb_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [gasb_pkg::QW-1:0] i_num,
    input  wire logic [gasb_pkg::QW-1:0] i_den,
    input  wire gasb_pkg::t_side      i_side,
    output logic                      o_valid,
    output logic [gasb_pkg::QW-1:0]   o_quo,
    output gasb_pkg::t_side           o_side
);

    localparam int N = gasb_pkg::QW;

    logic            r_v    [N];
    logic [N-1:0]    r_rem  [N];
    logic [N-1:0]    r_den  [N];
    logic [N-1:0]    r_quo  [N];
    gasb_pkg::t_side r_side [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic [N:0]      n_trial;
        logic [N-1:0]    n_dv;
        logic [N-1:0]    n_qin;
        gasb_pkg::t_side n_sd;
        logic            n_vin;
        logic            n_bit;

        if (j == 0) begin : g_first
            // integer bit: num >= den
            assign n_trial = {1'b0, i_num};
            assign n_dv = i_den;
            assign n_qin = '0;
            assign n_sd = i_side;
            assign n_vin = i_valid;
        end else begin : g_next
            assign n_trial = {r_rem[j-1], 1'b0};
            assign n_dv = r_den[j-1];
            assign n_qin = r_quo[j-1];
            assign n_sd = r_side[j-1];
            assign n_vin = r_v[j-1];
        end

        assign n_bit = (n_trial >= {1'b0, n_dv});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= n_vin;
            end
            r_rem[j] <= n_bit ? N'(n_trial - {1'b0, n_dv}) : n_trial[N-1:0];
            r_quo[j] <= {n_qin[N-2:0], n_bit};
            r_den[j] <= n_dv;
            r_side[j] <= n_sd;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo = r_quo[N-1];
    assign o_side = r_side[N-1];

endmodule
`default_nettype wire

// ===== src/gasb_norm.sv =====
// Denominator of the arctangent ratio: den = ONE + 0.28 * t^2, two stages.
// Uses gasb_pkg.
`default_nettype none
module gasb_norm (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [gasb_pkg::QW-1:0] i_t,
    input  wire gasb_pkg::t_side      i_side,
    output logic                      o_valid,
    output logic [gasb_pkg::QW-1:0]   o_t,
    output logic [gasb_pkg::QW-1:0]   o_den,
    output gasb_pkg::t_side           o_side
);

    localparam int QW = gasb_pkg::QW;
    localparam int FB = gasb_pkg::FB;

    logic [1:0] r_v;
    logic [QW-1:0] r_t0, r_t1, r_s, r_den;
    logic [2*QW-1:0] n_sq, n_cs;
    gasb_pkg::t_side r_side0, r_side1;

    // t^2 then 0.28 * s, each floored by FB bits
    assign n_sq = (2*QW)'(i_t) * (2*QW)'(i_t);
    assign n_cs = (2*QW)'(gasb_pkg::C028_Q) * (2*QW)'(r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[0], i_valid};
        end
        r_t0 <= i_t;
        r_s <= n_sq[FB+QW-1:FB];
        r_side0 <= i_side;
        r_t1 <= r_t0;
        r_den <= gasb_pkg::ONE_Q + n_cs[FB+QW-1:FB];
        r_side1 <= r_side0;
    end

    assign o_valid = r_v[1];
    assign o_t = r_t1;
    assign o_den = r_den;
    assign o_side = r_side1;

endmodule
`default_nettype wire

// ===== src/gasb_bucket.sv =====
// Angle assembly and bucket quantization: theta, theta * count, division by
// two pi one bit per stage, clamp. Uses gasb_pkg.
`default_nettype none
module gasb_bucket (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [gasb_pkg::QW-1:0] i_rat,
    input  wire gasb_pkg::t_side      i_side,
    input  wire logic [gasb_pkg::AW-1:0] i_angle_count,
    output logic                      o_valid,
    output gasb_pkg::t_result         o_result
);

    localparam int QW = gasb_pkg::QW;
    localparam int OW = gasb_pkg::OW;
    localparam int PW = gasb_pkg::PW;
    localparam int BQ = gasb_pkg::BQ;
    localparam int AW = gasb_pkg::AW;
    localparam logic [AW-1:0] MAX_BUCKET = 7'd63;

    logic r_vt, r_vp, r_vo;
    logic [OW-1:0] r_theta;
    logic [PW-1:0] r_prod;
    logic [1:0] r_st_t, r_st_p;
    logic signed [OW+1:0] n_sum, n_rat;
    logic [OW-1:0] n_theta;

    logic          r_v   [BQ];
    logic [PW-1:0] r_rem [BQ];
    logic [BQ-1:0] r_quo [BQ];
    logic [1:0]    r_st  [BQ];

    logic [AW-1:0] n_limit, n_bucket;
    gasb_pkg::t_result r_res;

    // theta = offset + pi +/- ratio term, floored at zero
    always_comb begin
        n_rat = $signed({{(OW+2-QW){1'b0}}, i_rat});
        n_sum = $signed({2'b00, i_side.offp}) + (i_side.neg ? -n_rat : n_rat);
        n_theta = n_sum[OW+1] ? '0 : n_sum[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= 1'b0;
            r_vp <= 1'b0;
        end else begin
            r_vt <= i_valid;
            r_vp <= r_vt;
        end
        r_theta <= n_theta;
        r_st_t <= i_side.strength;
        r_prod <= PW'(r_theta) * PW'(i_angle_count);
        r_st_p <= r_st_t;
    end

    // long division by two pi, most significant quotient bit first
    for (genvar k = 0; k < BQ; k++) begin : g_qbit
        localparam logic [PW-1:0] DIVK = PW'(gasb_pkg::TWO_PI_FX) << (BQ - 1 - k);
        logic [PW-1:0] n_in;
        logic [BQ-1:0] n_qin;
        logic [1:0]    n_sin;
        logic          n_vin;
        logic          n_bit;

        if (k == 0) begin : g_first
            assign n_in = r_prod;
            assign n_qin = '0;
            assign n_sin = r_st_p;
            assign n_vin = r_vp;
        end else begin : g_next
            assign n_in = r_rem[k-1];
            assign n_qin = r_quo[k-1];
            assign n_sin = r_st[k-1];
            assign n_vin = r_v[k-1];
        end

        assign n_bit = (n_in >= DIVK);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= n_vin;
            end
            r_rem[k] <= n_bit ? n_in - DIVK : n_in;
            r_quo[k] <= {n_qin[BQ-2:0], n_bit};
            r_st[k] <= n_sin;
        end
    end

    // clamp to angle_count - 1, at most 63; zero when angle_count is zero
    always_comb begin
        if (i_angle_count == '0) n_limit = '0;
        else if (i_angle_count - 7'd1 > MAX_BUCKET) n_limit = MAX_BUCKET;
        else n_limit = i_angle_count - 7'd1;
        n_bucket = (r_quo[BQ-1] > n_limit) ? n_limit : r_quo[BQ-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[BQ-1];
        end
        r_res.angle_bucket <= n_bucket[5:0];
        r_res.strength_class <= r_st[BQ-1];
    end

    assign o_valid = r_vo;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ===== src/gradient_angle_strength_bucket_core.sv =====
// An accepted start runs through front end, dividers, norm and bucket to o_done.
// Throughput: one patch per cycle; busy stays low, set by the two 25-stage
// one-bit-per-stage dividers that keep every stage busy each cycle.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits and sets angle_count to 24.
`default_nettype none
`include "assert_macros.svh"
module gradient_angle_strength_bucket_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command channel
    input  wire logic              start,
    output logic                   busy,
    input  wire gasb_pkg::t_patch  i_patch,
    output logic                   o_done,
    output gasb_pkg::t_result      o_result,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int QW = gasb_pkg::QW;
    localparam int AW = gasb_pkg::AW;

    logic [AW-1:0] r_angle_count;
    logic in_fire;
    logic f_valid, d1_valid, nm_valid, d2_valid;
    logic [QW-1:0] f_num, f_den, d1_quo, nm_t, nm_den, d2_quo;
    gasb_pkg::t_side f_side, d1_side, nm_side, d2_side;

    // register file
    assign pready = 1'b1;
    assign busy = 1'b0;
    assign in_fire = start && !busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_count <= gasb_pkg::ANGLE_COUNT_RST;
        end else if (psel && penable && pwrite
                     && paddr[2] == gasb_pkg::REG_ANGLE_COUNT) begin
            r_angle_count <= pwdata[AW-1:0];
        end
    end
    assign prdata = (paddr[2] == gasb_pkg::REG_ANGLE_COUNT) ? 32'(r_angle_count) : '0;

    gasb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_fire), .i_patch(i_patch),
        .o_valid(f_valid), .o_num(f_num), .o_den(f_den), .o_side(f_side)
    );

    // t = n / d
    gasb_div u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_num(f_num),
        .i_den(f_den), .i_side(f_side),
        .o_valid(d1_valid), .o_quo(d1_quo), .o_side(d1_side)
    );

    gasb_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(d1_valid), .i_t(d1_quo),
        .i_side(d1_side), .o_valid(nm_valid), .o_t(nm_t), .o_den(nm_den),
        .o_side(nm_side)
    );

    // ratio term = t / (1 + 0.28 t^2)
    gasb_div u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(nm_valid), .i_num(nm_t),
        .i_den(nm_den), .i_side(nm_side),
        .o_valid(d2_valid), .o_quo(d2_quo), .o_side(d2_side)
    );

    gasb_bucket u_bucket (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(d2_valid), .i_rat(d2_quo),
        .i_side(d2_side), .i_angle_count(r_angle_count),
        .o_valid(o_done), .o_result(o_result)
    );

    // checks
    `ASSERT_CLK_RST(a_done_src, i_clk, i_rst_n, o_done |-> $past(in_fire, gasb_pkg::LATENCY))
    `ASSERT_CLK_RST(a_start_done, i_clk, i_rst_n, in_fire |-> ##(gasb_pkg::LATENCY) o_done)
    `ASSERT_NEVER(a_strength, i_clk, i_rst_n, o_done && o_result.strength_class > gasb_pkg::STR_STRONG)
    `ASSERT_NEVER(a_bucket, i_clk, i_rst_n, o_done && r_angle_count != '0 && AW'(o_result.angle_bucket) >= r_angle_count)

endmodule
`default_nettype wire
